// ----- src/dbcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types and codes of the debug breakpoint and call stack unit.
// ----------------------------------------------------------------------------
package dbcs_pkg;

	localparam int OFF_W = 12;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		CMD_CHECK   = 4'd0,
		CMD_SET_BP  = 4'd1,
		CMD_CLR_BP  = 4'd2,
		CMD_CLR_ALL = 4'd3,
		CMD_HALT    = 4'd4,
		CMD_STEP    = 4'd5,
		CMD_CONT    = 4'd6,
		CMD_CALL    = 4'd7,
		CMD_RETADDR = 4'd8,
		CMD_SP_RISE = 4'd9,
		CMD_READ    = 4'd10,
		CMD_NOP     = 4'd15
	} cmd_t;

	localparam logic [1:0] TAG_NONE  = 2'd0;
	localparam logic [1:0] TAG_START = 2'd1;
	localparam logic [1:0] TAG_NEXT  = 2'd2;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_OVER  = 2'd1;
	localparam logic [1:0] FAULT_UNDER = 2'd2;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [13:0] prog_addr;
		logic [13:0] origin_addr;
		logic [11:0] data_addr;
		logic [63:0] cycle_count;
		logic [5:0]  stack_index;
	} item_t;

	typedef struct packed {
		logic        stop;
		logic        halted_now;
		logic        step_pending;
		logic [6:0]  call_depth;
		logic [13:0] entry_target;
		logic [13:0] entry_origin;
		logic [1:0]  fault;
	} result_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [13:0]      pa;
		logic [13:0]      oa;
		logic [OFF_W-1:0] off;
		logic [63:0]      cyc;
		logic [5:0]       si;
		logic             pa_ok;
		logic             addr_ok;
	} op_t;

endpackage

// ----- src/dbcs_front.sv -----
// ----------------------------------------------------------------------------
// dbcs_front
// Accepts input transfers and classifies them into queue operations.
// ----------------------------------------------------------------------------
module dbcs_front #(
	parameter int PROG_WORDS = 16384,
	parameter int SRAM_BYTES = 2560,
	parameter int SRAM_BASE = 256
) (
	input  logic            item_valid,
	output logic            item_ready,
	input  dbcs_pkg::item_t item,
	input  logic            q_full,
	input  logic            clearing,
	output logic            q_push,
	output dbcs_pkg::op_t   q_wdata
);
	import dbcs_pkg::*;

	localparam logic [16:0] PW_LIM = 17'(PROG_WORDS);
	localparam logic [16:0] SB_LIM = 17'(SRAM_BYTES);
	localparam logic [16:0] SB_LAST = 17'(SRAM_BYTES - 1);
	localparam logic [12:0] BASE = 13'(SRAM_BASE);

	logic [12:0]      diff;
	logic             da_ge;
	logic             da_in;
	logic [OFF_W-1:0] off_raw;
	logic [OFF_W-1:0] off_clip;
	cmd_t             cmd;

	assign item_ready = !q_full && !clearing;
	assign q_push = item_valid && item_ready;

	always_comb begin
		diff = {1'b0, item.data_addr} - BASE;
		da_ge = {1'b0, item.data_addr} >= BASE;
		off_raw = diff[OFF_W-1:0];
		da_in = da_ge && (17'(off_raw) < SB_LIM);
		off_clip = (17'(off_raw) > SB_LAST) ? SB_LAST[OFF_W-1:0] : off_raw;
		cmd = (item.cmd > 4'(CMD_READ)) ? CMD_NOP : cmd_t'(item.cmd);
		q_wdata.cmd = cmd;
		q_wdata.pa = item.prog_addr;
		q_wdata.oa = item.origin_addr;
		q_wdata.cyc = item.cycle_count;
		q_wdata.si = item.stack_index;
		q_wdata.pa_ok = 17'(item.prog_addr) < PW_LIM;
		q_wdata.off = (cmd == CMD_SP_RISE) ? off_clip : off_raw;
		q_wdata.addr_ok = (cmd == CMD_SP_RISE) ? da_ge : da_in;
	end

endmodule

// ----- src/dbcs_queue.sv -----
// ----------------------------------------------------------------------------
// dbcs_queue
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module dbcs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dbcs_pkg::op_t wdata,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output dbcs_pkg::op_t rdata
);
	import dbcs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign full = cnt_q == NW'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/dbcs_back.sv -----
// ----------------------------------------------------------------------------
// dbcs_back
// Executes queued operations against the breakpoint map, the byte tags and
// the shadow call stack, and holds the result register.
// ----------------------------------------------------------------------------
module dbcs_back #(
	parameter int PROG_WORDS = 16384,
	parameter int CALL_DEPTH = 64,
	parameter int SRAM_BYTES = 2560
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dbcs_pkg::op_t     q_rdata,
	output logic              q_pop,
	output logic              clearing,
	output logic              result_valid,
	input  logic              result_ready,
	output dbcs_pkg::result_t result
);
	import dbcs_pkg::*;

	localparam int PW = $clog2(PROG_WORDS);
	localparam int TW = $clog2(SRAM_BYTES);
	localparam int CW = $clog2(CALL_DEPTH);
	localparam int DW = $clog2(CALL_DEPTH + 1);
	localparam int CLR_N = (PROG_WORDS > SRAM_BYTES) ? PROG_WORDS : SRAM_BYTES;
	localparam int KW = $clog2(CLR_N);
	localparam logic [16:0] CLR_LAST = 17'(CLR_N - 1);
	localparam logic [16:0] PW_LAST = 17'(PROG_WORDS - 1);
	localparam logic [16:0] PW_LIM = 17'(PROG_WORDS);
	localparam logic [16:0] SB_LIM = 17'(SRAM_BYTES);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_READ    = 8'b0000_0100,
		ST_TAG2    = 8'b0000_1000,
		ST_WALK_RD = 8'b0001_0000,
		ST_WALK_EV = 8'b0010_0000,
		ST_CLR_ALL = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [KW-1:0]     cnt_q;
	op_t               op_q;
	logic              halted_q;
	logic              step_q;
	logic [63:0]       skip_q;
	logic [DW-1:0]     depth_q;
	logic [OFF_W-1:0]  last_sp_q;
	logic [OFF_W:0]    walk_q;
	logic              stop_q;
	logic [13:0]       tgt_q;
	logic [13:0]       org_q;
	logic [1:0]        fault_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              brk_mem [PROG_WORDS];
	logic [1:0]        tag_mem [SRAM_BYTES];
	logic [27:0]       call_mem [CALL_DEPTH];
	logic              brk_rd;
	logic [1:0]        tag_rd;
	logic [27:0]       call_rd;

	logic              brk_we;
	logic              brk_re;
	logic [PW-1:0]     brk_wa;
	logic              brk_wd;
	logic              tag_we;
	logic              tag_re;
	logic [TW-1:0]     tag_wa;
	logic [1:0]        tag_wd;
	logic              cm_we;
	logic              cm_re;
	logic [CW-1:0]     cm_wa;
	logic [27:0]       cm_wd;

	logic [16:0]       cnt_x;
	logic [16:0]       pa_x;
	logic [16:0]       off_x;
	logic [16:0]       offm_x;
	logic [16:0]       walk_x;
	logic [10:0]       si_x;
	logic [10:0]       dm_x;
	logic [PW-1:0]     pa_idx;
	logic              out_free;
	logic              walk_end;
	logic              hit;

	assign cnt_x = 17'(cnt_q);
	assign pa_x = 17'(q_rdata.pa);
	assign off_x = 17'(q_rdata.off);
	assign offm_x = 17'(op_q.off) - 17'd1;
	assign walk_x = 17'(walk_q);
	assign si_x = 11'(q_rdata.si);
	assign dm_x = 11'(depth_q) - 11'd1;
	assign pa_idx = pa_x[PW-1:0];
	assign out_free = !out_valid_q || result_ready;
	assign walk_end = walk_q > {1'b0, op_q.off};
	assign hit = (op_q.pa_ok && brk_rd) || halted_q;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign clearing = state_q == ST_CLEAR;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		brk_we = 1'b0;
		brk_re = 1'b0;
		brk_wa = pa_idx;
		brk_wd = 1'b0;
		tag_we = 1'b0;
		tag_re = 1'b0;
		tag_wa = walk_x[TW-1:0];
		tag_wd = TAG_NONE;
		cm_we = 1'b0;
		cm_re = 1'b0;
		cm_wa = dm_x[CW-1:0];
		cm_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				brk_we = cnt_x < PW_LIM;
				brk_wa = cnt_x[PW-1:0];
				tag_we = cnt_x < SB_LIM;
				tag_wa = cnt_x[TW-1:0];
			end
			ST_CLR_ALL: begin
				brk_we = 1'b1;
				brk_wa = cnt_x[PW-1:0];
			end
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_rdata.cmd)
						CMD_CHECK: brk_re = q_rdata.pa_ok;
						CMD_SET_BP: begin
							brk_we = q_rdata.pa_ok;
							brk_wd = 1'b1;
						end
						CMD_CLR_BP: brk_we = q_rdata.pa_ok;
						CMD_CALL: begin
							cm_we = depth_q < DW'(CALL_DEPTH);
							cm_wa = depth_q[CW-1:0];
							cm_wd = {q_rdata.pa, q_rdata.oa};
						end
						CMD_RETADDR: begin
							tag_we = q_rdata.addr_ok;
							tag_wa = off_x[TW-1:0];
							tag_wd = TAG_START;
						end
						CMD_READ: cm_re = 1'b1;
						default: ;
					endcase
				end
			end
			ST_TAG2: begin
				tag_we = 1'b1;
				tag_wa = offm_x[TW-1:0];
				tag_wd = TAG_NEXT;
			end
			ST_WALK_RD: tag_re = !walk_end;
			ST_WALK_EV: begin
				tag_we = 1'b1;
				cm_we = (tag_rd == TAG_START) && (depth_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (brk_we) begin
			brk_mem[brk_wa] <= brk_wd;
		end
		if (brk_re) begin
			brk_rd <= brk_mem[pa_idx];
		end
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (tag_re) begin
			tag_rd <= tag_mem[walk_x[TW-1:0]];
		end
		if (cm_we) begin
			call_mem[cm_wa] <= cm_wd;
		end
		if (cm_re) begin
			call_rd <= call_mem[si_x[CW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			op_q <= '0;
			halted_q <= 1'b0;
			step_q <= 1'b0;
			skip_q <= '1;
			depth_q <= '0;
			last_sp_q <= '0;
			walk_q <= '0;
			stop_q <= 1'b0;
			tgt_q <= '0;
			org_q <= '0;
			fault_q <= FAULT_NONE;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_x == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLR_ALL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_x == PW_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						op_q <= q_rdata;
						stop_q <= 1'b0;
						tgt_q <= '0;
						org_q <= '0;
						fault_q <= FAULT_NONE;
						state_q <= ST_DONE;
						unique case (q_rdata.cmd)
							CMD_CHECK, CMD_READ: state_q <= ST_READ;
							CMD_CLR_ALL: begin
								cnt_q <= '0;
								state_q <= ST_CLR_ALL;
							end
							CMD_HALT: begin
								halted_q <= 1'b1;
								step_q <= 1'b0;
							end
							CMD_STEP: step_q <= 1'b1;
							CMD_CONT: begin
								halted_q <= 1'b0;
								skip_q <= q_rdata.cyc;
							end
							CMD_CALL: begin
								if (depth_q < DW'(CALL_DEPTH)) begin
									depth_q <= depth_q + 1'b1;
								end else begin
									fault_q <= FAULT_OVER;
								end
							end
							CMD_RETADDR: begin
								if (q_rdata.addr_ok) begin
									last_sp_q <= q_rdata.off;
									if (q_rdata.off != '0) begin
										state_q <= ST_TAG2;
									end
								end
							end
							CMD_SP_RISE: begin
								if (q_rdata.addr_ok) begin
									walk_q <= (last_sp_q != '0) ?
										{1'b0, last_sp_q - 1'b1} : '0;
									state_q <= ST_WALK_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (op_q.cmd == CMD_READ) begin
						if (11'(op_q.si) < 11'(depth_q)) begin
							tgt_q <= call_rd[27:14];
							org_q <= call_rd[13:0];
						end
					end else if (hit) begin
						step_q <= 1'b0;
						if (skip_q == op_q.cyc) begin
							halted_q <= 1'b0;
							stop_q <= 1'b0;
						end else begin
							halted_q <= 1'b1;
							stop_q <= !step_q;
						end
					end
					state_q <= ST_DONE;
				end
				ST_TAG2: state_q <= ST_DONE;
				ST_WALK_RD: begin
					if (walk_end) begin
						last_sp_q <= op_q.off;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK_EV;
					end
				end
				ST_WALK_EV: begin
					if (tag_rd == TAG_START) begin
						if (depth_q == '0) begin
							fault_q <= FAULT_UNDER;
						end else begin
							depth_q <= depth_q - 1'b1;
						end
					end
					walk_q <= walk_q + 1'b1;
					state_q <= ST_WALK_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.stop <= stop_q;
						out_q.halted_now <= halted_q;
						out_q.step_pending <= step_q;
						out_q.call_depth <= 7'(depth_q);
						out_q.entry_target <= tgt_q;
						out_q.entry_origin <= org_q;
						out_q.fault <= fault_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(CALL_DEPTH))
		else $error("call depth above its bound");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && fault_q == FAULT_OVER) |-> depth_q == DW'(CALL_DEPTH))
		else $error("overflow reported with room on the call stack");

	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_EV && tag_rd == TAG_START && depth_q != '0)
		|=> depth_q == $past(depth_q) - 1'b1)
		else $error("tagged byte did not pop one call");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !result_valid || $past(result_valid))
		else $error("result appeared during the clearing pass");
`endif

endmodule

// ----- src/debug_breakpoint_call_stack_unit.sv -----
// ----------------------------------------------------------------------------
// debug_breakpoint_call_stack_unit
// Breakpoint, halt and step control with a shadow call stack for a debug
// port of an emulated 8-bit core.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      item (item_t)
// result    out        result_valid / result_ready  result (result_t)
//
// A simple command goes from idle straight to the done state; an instruction
// check or a stack read first waits in the read state for its registered
// memory read. A return-address registration above the first SRAM byte adds
// a state for its second tag write.
// A stack-pointer rise adds a tag read and an evaluation for each released
// SRAM byte walked. Clear-all sweeps all PROG_WORDS breakpoint map entries.
// After reset a clearing pass over max(PROG_WORDS, SRAM_BYTES) entries runs
// with item_ready low.
// Results wait in an output register; the queue takes items until it is full.
// ----------------------------------------------------------------------------
module debug_breakpoint_call_stack_unit #(
	parameter int PROG_WORDS = 16384,
	parameter int CALL_DEPTH = 64,
	parameter int SRAM_BYTES = 2560,
	parameter int SRAM_BASE = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dbcs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output dbcs_pkg::result_t result
);
	import dbcs_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	logic clearing;
	op_t  q_wdata;
	op_t  q_rdata;

	dbcs_front #(
		.PROG_WORDS(PROG_WORDS),
		.SRAM_BYTES(SRAM_BYTES),
		.SRAM_BASE(SRAM_BASE)
	) u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.q_full(q_full),
		.clearing(clearing),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	dbcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.full(q_full),
		.empty(q_empty),
		.rdata(q_rdata)
	);

	dbcs_back #(
		.PROG_WORDS(PROG_WORDS),
		.CALL_DEPTH(CALL_DEPTH),
		.SRAM_BYTES(SRAM_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_rdata(q_rdata),
		.q_pop(q_pop),
		.clearing(clearing),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
